/* rtl/core/obcs_pkg.sv */
package obcs_pkg;

    // table size and index width
    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // field widths
    localparam int SLOT_W = 4;
    localparam int POS_W  = 16;
    localparam int EXT_W  = 8;
    localparam int DIR_W  = 2;

    // request kinds carried on tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // sign codes, two's complement
    localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
    localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

    // broad test window on the whole-byte difference
    localparam logic [EXT_W-1:0] NEAR_HI = 8'd2;
    localparam logic [EXT_W-1:0] NEAR_LO = 8'd254;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [EXT_W-1:0]  w;
        logic [EXT_W-1:0]  h;
        logic              active;
    } t_req;

    typedef struct packed {
        logic wr;     // load this request into the addressed slot
        logic query;  // capture match results for this request
    } t_cell_ctl;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [DIR_W-1:0]  dir_x;
        logic [DIR_W-1:0]  dir_y;
    } t_pick;

    function automatic logic [DIR_W-1:0] sign_code(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
        logic [DIR_W-1:0] r;
        if (a > b) begin
            r = DIR_POS;
        end else if (a < b) begin
            r = DIR_NEG;
        end else begin
            r = DIR_ZERO;
        end
        return r;
    endfunction

endpackage

/* rtl/core/obcs_cell.sv */
module obcs_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [obcs_pkg::IDX_W-1:0] i_cell_idx,
    input  obcs_pkg::t_cell_ctl      i_ctl,
    input  obcs_pkg::t_req           i_req,
    input  obcs_pkg::t_pick          i_pick,
    output obcs_pkg::t_pick          o_pick
);

    logic [obcs_pkg::POS_W-1:0] r_x;
    logic [obcs_pkg::POS_W-1:0] r_y;
    logic [obcs_pkg::EXT_W-1:0] r_w;
    logic [obcs_pkg::EXT_W-1:0] r_h;
    logic                       r_active;
    logic                       r_hit;
    logic [obcs_pkg::DIR_W-1:0] r_dx;
    logic [obcs_pkg::DIR_W-1:0] r_dy;

    logic                       self_sel;
    logic [obcs_pkg::EXT_W-1:0] dwx;
    logic [obcs_pkg::EXT_W-1:0] dwy;
    logic                       near_x;
    logic                       near_y;
    logic [obcs_pkg::POS_W:0]   q_end_x;
    logic [obcs_pkg::POS_W:0]   q_end_y;
    logic [obcs_pkg::POS_W:0]   e_end_x;
    logic [obcs_pkg::POS_W:0]   e_end_y;
    logic                       ovl_x;
    logic                       ovl_y;
    logic                       n_hit;

    // slot number compare done wide enough for either width
    assign self_sel = (7'(i_req.slot) == 7'(i_cell_idx));

    assign dwx    = i_req.x[15:8] - r_x[15:8];
    assign dwy    = i_req.y[15:8] - r_y[15:8];
    assign near_x = (dwx <= obcs_pkg::NEAR_HI) || (dwx >= obcs_pkg::NEAR_LO);
    assign near_y = (dwy <= obcs_pkg::NEAR_HI) || (dwy >= obcs_pkg::NEAR_LO);

    // edges at 17 bits, strict overlap
    assign q_end_x = {1'b0, i_req.x} + 17'(i_req.w);
    assign q_end_y = {1'b0, i_req.y} + 17'(i_req.h);
    assign e_end_x = {1'b0, r_x} + 17'(r_w);
    assign e_end_y = {1'b0, r_y} + 17'(r_h);
    assign ovl_x   = (e_end_x > {1'b0, i_req.x}) && (q_end_x > {1'b0, r_x});
    assign ovl_y   = (e_end_y > {1'b0, i_req.y}) && (q_end_y > {1'b0, r_y});

    assign n_hit = r_active && !self_sel && near_x && near_y && ovl_x && ovl_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (i_ctl.wr && self_sel) begin
                r_active <= i_req.active;
            end
            if (i_ctl.query) begin
                r_hit <= n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && self_sel) begin
            r_x <= i_req.x;
            r_y <= i_req.y;
            r_w <= i_req.w;
            r_h <= i_req.h;
        end
        if (i_ctl.query) begin
            r_dx <= obcs_pkg::sign_code(i_req.x, r_x);
            r_dy <= obcs_pkg::sign_code(i_req.y, r_y);
        end
    end

    // lower cells win: pass an upstream find through untouched
    always_comb begin
        if (i_pick.found) begin
            o_pick = i_pick;
        end else if (r_hit) begin
            o_pick.found = 1'b1;
            o_pick.slot  = obcs_pkg::SLOT_W'(i_cell_idx);
            o_pick.dir_x = r_dx;
            o_pick.dir_y = r_dy;
        end else begin
            o_pick = i_pick;
        end
    end

endmodule

/* rtl/core/object_box_collision_scan_core.sv */
// Object box collision scan.
// Slave channel s_axis_*: one request per handshake. tuser is the kind:
// write loads one slot entry (no result); query checks a box against all
// other active slots. Master channel m_axis_*: one result per query.
// Each slot lives in its own cell; a query is compared in every cell at
// once on the accepting edge, the per-cell hits are held, and in the next
// cycle a priority pick ripples through the row of cells from slot 0 up,
// so the lowest matching slot wins.
// m_axis_tvalid rises once the pick has moved into the output register. No new
// request is taken while a query sits in the cells, until its pick moves out;
// writes are taken every cycle when no query is in the cells.
// s_axis_tready drops while a query sits in the cells, and stays
// low while a finished result cannot move into the output register because
// the receiver holds m_axis_tready low; one result can wait in the output
// register while the next request is accepted.
// Reset (i_rst_n, synchronous, active low) clears all active bits, the
// output valid and the pending query; entry payloads are left as they are.
module object_box_collision_scan_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] slot_index, [19:4] pos_x, [35:20] pos_y, [43:36] box_width,
    // [51:44] box_height, [52] active_flag, [55:53] zero
    input  logic [55:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] collided, [4:1] hit_slot, [6:5] push_dir_x, [8:7] push_dir_y,
    // [15:9] zero
    output logic [15:0] m_axis_tdata
);

    obcs_pkg::t_req      req;
    obcs_pkg::t_cell_ctl ctl;
    obcs_pkg::t_pick     chain [obcs_pkg::NUM_SLOTS+1];

    logic       s_fire;
    logic       r_busy;     // query results held in the cells
    logic       r_out_valid;
    logic [8:0] r_out_data;
    logic       move_out;

    assign req.slot   = s_axis_tdata[3:0];
    assign req.x      = s_axis_tdata[19:4];
    assign req.y      = s_axis_tdata[35:20];
    assign req.w      = s_axis_tdata[43:36];
    assign req.h      = s_axis_tdata[51:44];
    assign req.active = s_axis_tdata[52];

    assign s_axis_tready = !r_busy;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign ctl.wr        = s_fire && (s_axis_tuser == obcs_pkg::CMD_WRITE);
    assign ctl.query     = s_fire && (s_axis_tuser == obcs_pkg::CMD_QUERY);

    // head of the chain: nothing found yet
    assign chain[0] = '0;

    for (genvar g = 0; g < obcs_pkg::NUM_SLOTS; g++) begin : g_cell
        obcs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (obcs_pkg::IDX_W'(g)),
            .i_ctl      (ctl),
            .i_req      (req),
            .i_pick     (chain[g]),
            .o_pick     (chain[g+1])
        );
    end

    // pick moves out once the output register is free or being drained
    assign move_out = r_busy && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl.query) begin
                r_busy <= 1'b1;
            end else if (move_out) begin
                r_busy <= 1'b0;
            end
            if (move_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_out) begin
            r_out_data <= {chain[obcs_pkg::NUM_SLOTS].dir_y,
                           chain[obcs_pkg::NUM_SLOTS].dir_x,
                           chain[obcs_pkg::NUM_SLOTS].slot,
                           chain[obcs_pkg::NUM_SLOTS].found};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_data};

endmodule
